// ===== hdl/argb_to_yuv420_semiplanar_assert.svh =====
// Assertion macros shared by the RTL files.
`ifndef ARGB_TO_YUV420_SEMIPLANAR_ASSERT_SVH
`define ARGB_TO_YUV420_SEMIPLANAR_ASSERT_SVH

`ifndef SYNTHESIS
`define ARGBYUV_ASSERT_HOLDS(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error(msg);
`define ARGBYUV_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`else
`define ARGBYUV_ASSERT_HOLDS(lbl, clk, rst, expr, msg)
`define ARGBYUV_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ===== hdl/argbyuv_pkg.sv =====
`default_nettype none
package argbyuv_pkg;

  localparam int ADDR_W      = 25;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_INDEX_W = 2;
  localparam int QUEUE_DEPTH = 4;

  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_CHROMA_ORDER = 2'd2
  } argbyuv_reg_t;

  typedef enum logic [2:0] {
    BEAT_LUMA   = 3'b001,
    BEAT_FIRST  = 3'b010,
    BEAT_SECOND = 3'b100
  } argbyuv_beat_t;

  // One classified pixel, as the front hands it to the back.
  typedef struct packed {
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic              chroma_here;
    logic              last_pixel;
    logic              chroma_order;
    logic [ADDR_W-1:0] luma_address;
    logic [ADDR_W-1:0] chroma_address;
  } argbyuv_job_t;

  // Converted pixel waiting to be sent as one or three beats.
  typedef struct packed {
    logic [7:0]        luma;
    logic [7:0]        first;
    logic [7:0]        second;
    logic              chroma_here;
    logic              last_pixel;
    logic [ADDR_W-1:0] luma_address;
    logic [ADDR_W-1:0] chroma_address;
  } argbyuv_work_t;

  // Sum peaks at 56228, so the top byte never exceeds 219 and no clamp is needed.
  function automatic logic [7:0] luma_of(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    logic [15:0] s;
    s = 16'd66 * {8'd0, r} + 16'd129 * {8'd0, g} + 16'd25 * {8'd0, b} + 16'd128;
    return s[15:8] + 8'd16;
  endfunction

  // Biased sums stay within 4336..61456, so the result lands in 16..240.
  function automatic logic [7:0] cb_of(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    logic [16:0] s;
    s = 17'd112 * {9'd0, b} + 17'd32896 - 17'd38 * {9'd0, r} - 17'd74 * {9'd0, g};
    return s[15:8];
  endfunction

  function automatic logic [7:0] cr_of(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    logic [16:0] s;
    s = 17'd112 * {9'd0, r} + 17'd32896 - 17'd94 * {9'd0, g} - 17'd18 * {9'd0, b};
    return s[15:8];
  endfunction

endpackage
`default_nettype wire

// ===== hdl/argbyuv_pix_if.sv =====
`default_nettype none
interface argbyuv_pix_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_word;

  modport source (output valid, output pixel_word, input ready);
  modport sink (input valid, input pixel_word, output ready);
endinterface
`default_nettype wire

// ===== hdl/argbyuv_byte_if.sv =====
`default_nettype none
interface argbyuv_byte_if import argbyuv_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] byte_address;
  logic [7:0]        byte_value;
  logic              is_chroma;
  logic              last_of_pixel;
  logic              frame_done;

  modport source (output valid, output byte_address, output byte_value, output is_chroma,
                  output last_of_pixel, output frame_done, input ready);
  modport sink (input valid, input byte_address, input byte_value, input is_chroma,
                input last_of_pixel, input frame_done, output ready);
endinterface
`default_nettype wire

// ===== hdl/argbyuv_queue.sv =====
`default_nettype none
`include "argb_to_yuv420_semiplanar_assert.svh"
module argbyuv_queue import argbyuv_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire argbyuv_job_t push_job,
  output logic              full,
  input  wire logic         pop,
  output argbyuv_job_t      head,
  output logic              not_empty
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  argbyuv_job_t     slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= PTR_W'(wr_ptr + 1'b1);
      if (do_pop) rd_ptr <= PTR_W'(rd_ptr + 1'b1);
      if (do_push && !do_pop) begin
        count <= CNT_W'(count + 1'b1);
      end else if (do_pop && !do_push) begin
        count <= CNT_W'(count - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_job;
  end

  `ARGBYUV_ASSERT_HOLDS(a_count_bounded, clk, rst, count <= CNT_W'(QUEUE_DEPTH), "queue overfilled")
  `ARGBYUV_ASSERT_IMPLIES(a_push_only_with_room, clk, rst, push, !full, "push into a full queue")

endmodule
`default_nettype wire

// ===== hdl/argbyuv_front.sv =====
`default_nettype none
`include "argb_to_yuv420_semiplanar_assert.svh"
module argbyuv_front import argbyuv_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  argbyuv_pix_if.sink                 pixels,
  output logic                        push,
  output argbyuv_job_t                push_job,
  input  wire logic                   full
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
  localparam int RST_W = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
  localparam int RST_H = (HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RESET;

  logic [WW-1:0]     eff_width;
  logic [HW-1:0]     eff_height;
  logic              chroma_order;
  logic [CW-1:0]     column_count;
  logic [RW-1:0]     row_count;
  logic [ADDR_W-1:0] luma_address;
  logic [ADDR_W-1:0] chroma_address;
  logic [ADDR_W-1:0] plane_size;
  logic [ADDR_W-1:0] plane_size_next;
  logic              restart_pending;
  logic              fire;
  logic              row_end;
  logic              col_end;
  logic              last_pixel;
  logic              chroma_here;

  function automatic logic [WW-1:0] clamp_width(logic [CFG_DATA_W-1:0] v);
    if (v < CFG_DATA_W'(2)) return WW'(2);
    if (32'(v) > 32'(MAX_WIDTH)) return WW'(MAX_WIDTH);
    return WW'(v);
  endfunction

  function automatic logic [HW-1:0] clamp_height(logic [CFG_DATA_W-1:0] v);
    if (v < CFG_DATA_W'(2)) return HW'(2);
    if (32'(v) > 32'(MAX_HEIGHT)) return HW'(MAX_HEIGHT);
    return HW'(v);
  endfunction

  assign plane_size_next = ADDR_W'(ADDR_W'(eff_width) * ADDR_W'(eff_height));

  assign pixels.ready = !full && !restart_pending;
  assign fire         = pixels.valid && pixels.ready;
  assign push         = fire;

  assign col_end     = (32'(column_count) + 32'd1) >= 32'(eff_width);
  assign row_end     = (32'(row_count) + 32'd1) >= 32'(eff_height);
  assign last_pixel  = col_end && row_end;
  assign chroma_here = !column_count[0] && !row_count[0];

  always_comb begin
    push_job.red            = pixels.pixel_word[23:16];
    push_job.green          = pixels.pixel_word[15:8];
    push_job.blue           = pixels.pixel_word[7:0];
    push_job.chroma_here    = chroma_here;
    push_job.last_pixel     = last_pixel;
    push_job.chroma_order   = chroma_order;
    push_job.luma_address   = luma_address;
    push_job.chroma_address = chroma_address;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eff_width       <= WW'(RST_W);
      eff_height      <= HW'(RST_H);
      chroma_order    <= 1'b0;
      column_count    <= '0;
      row_count       <= '0;
      luma_address    <= '0;
      chroma_address  <= ADDR_W'(RST_W * RST_H);
      plane_size      <= ADDR_W'(RST_W * RST_H);
      restart_pending <= 1'b0;
    end else begin
      plane_size <= plane_size_next;
      if (cfg_write) begin
        case (cfg_index)
          REG_FRAME_WIDTH: begin
            eff_width       <= clamp_width(cfg_data);
            column_count    <= '0;
            row_count       <= '0;
            luma_address    <= '0;
            restart_pending <= 1'b1;
          end
          REG_FRAME_HEIGHT: begin
            eff_height      <= clamp_height(cfg_data);
            column_count    <= '0;
            row_count       <= '0;
            luma_address    <= '0;
            restart_pending <= 1'b1;
          end
          REG_CHROMA_ORDER: chroma_order <= cfg_data[0];
          default: ;
        endcase
      end else if (restart_pending) begin
        // New size is in the registers now; reload the chroma base.
        chroma_address  <= plane_size_next;
        restart_pending <= 1'b0;
      end else if (fire) begin
        if (last_pixel) begin
          column_count   <= '0;
          row_count      <= '0;
          luma_address   <= '0;
          chroma_address <= plane_size;
        end else begin
          luma_address <= ADDR_W'(luma_address + 1'b1);
          if (chroma_here) chroma_address <= ADDR_W'(chroma_address + 2'd2);
          if (col_end) begin
            column_count <= '0;
            row_count    <= RW'(row_count + 1'b1);
          end else begin
            column_count <= CW'(column_count + 1'b1);
          end
        end
      end
    end
  end

  `ARGBYUV_ASSERT_HOLDS(a_column_in_row, clk, rst, 32'(column_count) < 32'(eff_width), "column past row end")
  `ARGBYUV_ASSERT_HOLDS(a_row_in_frame, clk, rst, 32'(row_count) < 32'(eff_height), "row past frame end")

endmodule
`default_nettype wire

// ===== hdl/argbyuv_back.sv =====
`default_nettype none
`include "argb_to_yuv420_semiplanar_assert.svh"
module argbyuv_back import argbyuv_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire argbyuv_job_t head,
  input  wire logic         not_empty,
  output logic              pop,
  argbyuv_byte_if.source    bytes
);

  argbyuv_work_t     job;
  argbyuv_work_t     job_next;
  logic              job_valid;
  argbyuv_beat_t     beat;
  argbyuv_beat_t     beat_next;
  logic              out_load;
  logic              job_done;

  logic              out_valid;
  logic [ADDR_W-1:0] out_address;
  logic [7:0]        out_value;
  logic              out_chroma;
  logic              out_last;
  logic              out_done;

  logic [ADDR_W-1:0] beat_address;
  logic [7:0]        beat_value;
  logic              beat_chroma;
  logic              beat_last;

  logic [7:0]        cb;
  logic [7:0]        cr;

  assign cb = cb_of(head.red, head.green, head.blue);
  assign cr = cr_of(head.red, head.green, head.blue);

  always_comb begin
    job_next.luma           = luma_of(head.red, head.green, head.blue);
    job_next.first          = head.chroma_order ? cb : cr;
    job_next.second         = head.chroma_order ? cr : cb;
    job_next.chroma_here    = head.chroma_here;
    job_next.last_pixel     = head.last_pixel;
    job_next.luma_address   = head.luma_address;
    job_next.chroma_address = head.chroma_address;
  end

  always_comb begin
    case (beat)
      BEAT_LUMA: begin
        beat_address = job.luma_address;
        beat_value   = job.luma;
        beat_chroma  = 1'b0;
        beat_last    = !job.chroma_here;
        beat_next    = BEAT_FIRST;
      end
      BEAT_FIRST: begin
        beat_address = job.chroma_address;
        beat_value   = job.first;
        beat_chroma  = 1'b1;
        beat_last    = 1'b0;
        beat_next    = BEAT_SECOND;
      end
      BEAT_SECOND: begin
        beat_address = ADDR_W'(job.chroma_address + 1'b1);
        beat_value   = job.second;
        beat_chroma  = 1'b1;
        beat_last    = 1'b1;
        beat_next    = BEAT_LUMA;
      end
      default: begin
        beat_address = job.luma_address;
        beat_value   = job.luma;
        beat_chroma  = 1'b0;
        beat_last    = 1'b1;
        beat_next    = BEAT_LUMA;
      end
    endcase
  end

  assign out_load = job_valid && (!out_valid || bytes.ready);
  assign job_done = out_load && beat_last;
  assign pop      = not_empty && (!job_valid || job_done);

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      beat      <= BEAT_LUMA;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (bytes.ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        job_valid <= 1'b1;
        beat      <= BEAT_LUMA;
      end else if (job_done) begin
        job_valid <= 1'b0;
        beat      <= BEAT_LUMA;
      end else if (out_load) begin
        beat <= beat_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) job <= job_next;
    if (out_load) begin
      out_address <= beat_address;
      out_value   <= beat_value;
      out_chroma  <= beat_chroma;
      out_last    <= beat_last;
      out_done    <= beat_last && job.last_pixel;
    end
  end

  assign bytes.valid         = out_valid;
  assign bytes.byte_address  = out_address;
  assign bytes.byte_value    = out_value;
  assign bytes.is_chroma     = out_chroma;
  assign bytes.last_of_pixel = out_last;
  assign bytes.frame_done    = out_done;

  `ARGBYUV_ASSERT_IMPLIES(a_chroma_beats_need_chroma, clk, rst, job_valid && beat != BEAT_LUMA, job.chroma_here, "chroma beat for a luma-only pixel")
  `ARGBYUV_ASSERT_IMPLIES(a_done_is_last, clk, rst, out_valid && out_done, out_last, "frame end on a non-final beat")

endmodule
`default_nettype wire

// ===== hdl/argb_to_yuv420_semiplanar.sv =====
// Channel   Dir  Beat contents
// pixels    in   pixel_word: ARGB, alpha ignored, raster order
// bytes     out  byte_address, byte_value, is_chroma, last_of_pixel, frame_done
// cfg       in   cfg_write / cfg_index / cfg_data: width, height, chroma order
//
// A pixel on an odd row or column yields one output beat; a pixel on an even row and even
// column yields three (luma, then two chroma). While bytes.ready holds, the output register sends
// one beat a cycle, so an odd row runs one pixel a cycle and an even row, with its chroma beats, runs slower.
// Accepted pixels wait in a 4-entry queue, so input and output stall independently.
// Reset selects 640x480 NV21 and starts at the frame origin with the output empty.
// A width or height write restarts the frame and holds pixels off until the chroma base is reloaded.
`default_nettype none
module argb_to_yuv420_semiplanar import argbyuv_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  argbyuv_pix_if.sink                 pixels,
  argbyuv_byte_if.source              bytes
);

  logic         push;
  argbyuv_job_t push_job;
  logic         full;
  logic         pop;
  argbyuv_job_t head;
  logic         not_empty;

  argbyuv_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixels    (pixels),
    .push      (push),
    .push_job  (push_job),
    .full      (full)
  );

  argbyuv_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty)
  );

  argbyuv_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .not_empty (not_empty),
    .pop       (pop),
    .bytes     (bytes)
  );

endmodule
`default_nettype wire
